>>> rtl/i2crr_pkg.sv
// Shared types and constants for the I2C single-register read master.
// No dependencies; imported by i2crr_phase and i2c_register_read_master_core.
package i2crr_pkg;

  localparam int STEP_W       = 7;
  localparam int PHASE_TICKS_W = 16;
  localparam int CFG_DATA_W   = 16;

  // Register indexes of the configuration port
  localparam logic CFG_DEV_ADDR    = 1'b0;
  localparam logic CFG_PHASE_TICKS = 1'b1;

  localparam logic [7:0] DEV_ADDR_RESET    = 8'hD0;
  localparam logic [15:0] PHASE_TICKS_RESET = 16'd100;
  localparam logic [7:0] READ_BIT          = 8'h01;

  // Sequence steps
  localparam logic [STEP_W-1:0] STEP_IDLE     = 7'd0;
  localparam logic [STEP_W-1:0] STEP_START    = 7'd1;
  localparam logic [STEP_W-1:0] STEP_START_LO = 7'd2;
  localparam logic [STEP_W-1:0] STEP_WR_DEV   = 7'd3;
  localparam logic [STEP_W-1:0] STEP_WR_REG   = 7'd22;
  localparam logic [STEP_W-1:0] STEP_RESTART  = 7'd41;
  localparam logic [STEP_W-1:0] STEP_RESTART_LO = 7'd42;
  localparam logic [STEP_W-1:0] STEP_WR_RD    = 7'd43;
  localparam logic [STEP_W-1:0] STEP_RD_DATA  = 7'd62;
  localparam logic [STEP_W-1:0] STEP_STOP_LO  = 7'd81;
  localparam logic [STEP_W-1:0] STEP_LAST     = 7'd82;
  localparam logic [STEP_W-1:0] BYTE_SPAN     = 7'd18;  // last offset within a byte

  localparam logic [4:0] OFF_ACK_LO  = 5'd16;
  localparam logic [4:0] OFF_RELEASE = 5'd17;

  typedef struct packed {
    logic       start_read;
    logic [7:0] reg_addr;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
  } out_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] shift;
    logic [2:0] bit_idx;
  } line_t;

endpackage

>>> rtl/i2c_register_read_master_core.sv
// Top level of the I2C single-register read master: sequencer state,
// phase timing, configuration registers and output register.
// Depends on i2crr_pkg and i2crr_phase.
//
// Usage: each input word is one bus tick carrying start_read, reg_addr and the
// sampled sda_in; each accepted word yields exactly one output word with the
// scl/sda levels for that tick, busy, done and the last read byte.
// A start while idle latches reg_addr and runs 82 bus phases (start, device
// write address, register address, repeated start, device read address,
// eight read bits with NACK, stop), each held phase_ticks ticks (0 acts as 1).
// Each output word is registered from its input word. Throughput: one word
// per cycle while the receiver takes words, set by the single output register;
// a new word is taken when the output register is empty or its word is taken
// in the same cycle. When the receiver stalls, the output word holds and
// in_ready drops; no word is lost. Reset idles the sequencer with both lines
// released, clears the stored read byte and loads the default configuration
// (address 0xD0, 100 ticks). Configuration writes take effect on the next tick.
module i2c_register_read_master_core import i2crr_pkg::*; #(
  parameter int PHASE_COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = (PHASE_COUNT_BITS > PHASE_TICKS_W) ? PHASE_COUNT_BITS : PHASE_TICKS_W;

  logic [7:0]                  dev_addr;
  logic [PHASE_TICKS_W-1:0]    phase_ticks;
  logic [STEP_W-1:0]           step, step_next;
  logic [PHASE_COUNT_BITS-1:0] cnt, cnt_next;
  line_t                       lines, lines_next;
  logic [7:0]                  latched, latched_next;
  logic [7:0]                  result_byte, result_next;

  logic                        in_fire;
  logic [STEP_W-1:0]           step_a;
  logic [PHASE_COUNT_BITS-1:0] cnt_a, cnt_inc;
  line_t                       lines_a, lines_s, phase_out;
  logic [CW-1:0]               ticks_ext, cmax, limit;
  logic                        hit, busy, done, sample;
  logic                        scl_o, sda_o;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign ticks_ext = CW'(phase_ticks);
  assign cmax      = CW'({PHASE_COUNT_BITS{1'b1}});

  always_comb begin
    limit = (ticks_ext > cmax) ? cmax : ticks_ext;
    if (limit == '0) begin
      limit = CW'(1);
    end
  end

  i2crr_phase u_phase (
    .step     (step_a + 7'd1),
    .dev_addr (dev_addr),
    .reg_byte (latched_next),
    .cur      (lines_s),
    .nxt      (phase_out)
  );

  always_comb begin
    step_a       = step;
    cnt_a        = cnt;
    lines_a      = lines;
    latched_next = latched;
    if (step == STEP_IDLE && in_data.start_read) begin
      latched_next = in_data.reg_addr;
      step_a       = STEP_START;
      cnt_a        = '0;
      lines_a.scl  = 1'b1;
      lines_a.sda  = 1'b1;
    end
    scl_o = lines_a.scl;
    sda_o = lines_a.sda;

    busy    = (step_a != STEP_IDLE);
    cnt_inc = cnt_a + 1'b1;
    hit     = busy && (CW'(cnt_inc) >= limit);
    // read bits sampled at the end of each clock-high phase
    sample  = (step_a >= STEP_RD_DATA + 7'd1) && (step_a <= STEP_RD_DATA + 7'd15) &&
              step_a[0];
    lines_s = lines_a;
    if (sample) begin
      lines_s.shift = {lines_a.shift[6:0], in_data.sda_in};
    end

    step_next   = step_a;
    cnt_next    = cnt_a;
    lines_next  = lines_a;
    result_next = result_byte;
    done        = 1'b0;
    if (busy) begin
      cnt_next = cnt_inc;
      if (hit) begin
        cnt_next = '0;
        if (step_a >= STEP_LAST) begin
          result_next    = lines_s.shift;
          step_next      = STEP_IDLE;
          lines_next     = lines_s;
          lines_next.scl = 1'b1;
          lines_next.sda = 1'b1;
          done           = 1'b1;
        end else begin
          step_next  = step_a + 7'd1;
          lines_next = phase_out;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_addr    <= DEV_ADDR_RESET;
      phase_ticks <= PHASE_TICKS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_DEV_ADDR:    dev_addr    <= cfg_data[7:0];
        CFG_PHASE_TICKS: phase_ticks <= cfg_data[PHASE_TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= STEP_IDLE;
      cnt           <= '0;
      lines.scl     <= 1'b1;
      lines.sda     <= 1'b1;
      lines.shift   <= 8'd0;
      lines.bit_idx <= 3'd0;
      latched       <= 8'd0;
      result_byte   <= 8'd0;
      out_valid     <= 1'b0;
    end else begin
      if (in_fire) begin
        step        <= step_next;
        cnt         <= cnt_next;
        lines       <= lines_next;
        latched     <= latched_next;
        result_byte <= result_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data.scl_level <= scl_o;
      out_data.sda_drive <= sda_o;
      out_data.busy_res  <= busy;
      out_data.done_res  <= done;
      out_data.read_data <= result_next;
    end
  end

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> out_data.busy_res)
    else $error("done word without busy");

  a_idle_lines: assert property (@(posedge clk) disable iff (rst)
    step == STEP_IDLE |-> lines.scl && lines.sda)
    else $error("lines not released while idle");

  a_done_idles: assert property (@(posedge clk) disable iff (rst)
    in_fire && done |=> step == STEP_IDLE && cnt == '0)
    else $error("sequencer not idle after stop");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    in_fire && !done |=> $stable(result_byte))
    else $error("read byte changed outside done");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> $stable(step) && $stable(cnt))
    else $error("sequencer advanced without a word");

endmodule

>>> rtl/i2crr_phase.sv
// Bus line decoder: line levels and shift state on entry to a sequence step.
// Depends on i2crr_pkg.
module i2crr_phase import i2crr_pkg::*; (
  input  logic [STEP_W-1:0] step,
  input  logic [7:0]        dev_addr,
  input  logic [7:0]        reg_byte,
  input  line_t             cur,
  output line_t             nxt
);

  logic             in_wr_dev, in_wr_reg, in_wr_rd, in_rd, in_wr;
  logic [STEP_W-1:0] base;
  logic [STEP_W-1:0] diff;
  logic [4:0]       off;
  logic [7:0]       wr_byte;

  assign in_wr_dev = (step >= STEP_WR_DEV)  && (step <= STEP_WR_DEV + BYTE_SPAN);
  assign in_wr_reg = (step >= STEP_WR_REG)  && (step <= STEP_WR_REG + BYTE_SPAN);
  assign in_wr_rd  = (step >= STEP_WR_RD)   && (step <= STEP_WR_RD + BYTE_SPAN);
  assign in_rd     = (step >= STEP_RD_DATA) && (step <= STEP_RD_DATA + BYTE_SPAN);
  assign in_wr     = in_wr_dev || in_wr_reg || in_wr_rd;

  always_comb begin
    base    = STEP_RD_DATA;
    wr_byte = dev_addr | READ_BIT;
    if (in_wr_dev) begin
      base    = STEP_WR_DEV;
      wr_byte = dev_addr;
    end else if (in_wr_reg) begin
      base    = STEP_WR_REG;
      wr_byte = reg_byte;
    end else if (in_wr_rd) begin
      base    = STEP_WR_RD;
    end
  end

  assign diff = step - base;
  assign off  = diff[4:0];

  always_comb begin
    nxt = cur;
    if (step == STEP_START || step == STEP_RESTART) begin
      nxt.sda = 1'b1;
      nxt.scl = 1'b1;
    end else if (step == STEP_START_LO || step == STEP_RESTART_LO) begin
      nxt.sda = 1'b0;
    end else if (in_wr) begin
      if (off < OFF_ACK_LO) begin
        if (!off[0]) begin
          if (off == 5'd0) begin
            nxt.shift   = wr_byte;
            nxt.bit_idx = 3'd0;
          end
          nxt.scl = 1'b0;
        end else begin
          nxt.sda     = cur.shift[7];
          nxt.shift   = {cur.shift[6:0], 1'b0};
          nxt.bit_idx = cur.bit_idx + 3'd1;
          nxt.scl     = 1'b1;
        end
      end else if (off == OFF_ACK_LO) begin
        nxt.scl = 1'b0;
      end else if (off == OFF_RELEASE) begin
        nxt.sda = 1'b1;
      end else begin
        nxt.scl = 1'b1;
      end
    end else if (in_rd) begin
      if (off == 5'd0) begin
        nxt.sda     = 1'b1;
        nxt.scl     = 1'b0;
        nxt.shift   = 8'd0;
        nxt.bit_idx = 3'd0;
      end else if (off <= OFF_ACK_LO) begin
        nxt.scl = off[0];
      end else if (off == OFF_RELEASE) begin
        nxt.sda = 1'b1;
      end else begin
        nxt.scl = 1'b1;
      end
    end else if (step == STEP_STOP_LO) begin
      nxt.sda = 1'b0;
      nxt.scl = 1'b1;
    end else if (step == STEP_LAST) begin
      nxt.sda = 1'b1;
    end
  end

endmodule

>>> test/i2crr_bus_checker.sv
`timescale 1ns / 100ps
// Bus checker for i2c_register_read_master_core: watches both word channels
// and the config port, predicts each output word and compares. Uses i2crr_pkg.
module i2crr_bus_checker import i2crr_pkg::*; #(
  parameter int CNT_W = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_t                   in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_t                  out_data,
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    pending
);

  localparam logic [32:0] CNT_MAX = (33'd1 << CNT_W) - 33'd1;

  logic [7:0]               dev_addr;
  logic [PHASE_TICKS_W-1:0] hold_ticks;
  logic [STEP_W-1:0]        step;
  logic [CNT_W-1:0]         hold_count;
  logic [7:0]               shreg;
  logic [7:0]               latched_reg;
  logic [7:0]               last_byte;
  logic                     scl_q;
  logic                     sda_q;
  int                       mismatches = 0;
  out_t                     expected_bus_words[$];

  assign errors = mismatches;

  function automatic void reset_model();
    dev_addr    = DEV_ADDR_RESET;
    hold_ticks  = PHASE_TICKS_RESET;
    step        = STEP_IDLE;
    hold_count  = '0;
    shreg       = '0;
    latched_reg = '0;
    last_byte   = '0;
    scl_q       = 1'b1;
    sda_q       = 1'b1;
  endfunction

  function automatic void write_byte_phase(logic [STEP_W-1:0] off, logic [7:0] value);
    if (off == 0) shreg = value;
    if (off < OFF_ACK_LO) begin
      if (!off[0]) begin
        scl_q = 1'b0;
      end else begin
        sda_q = shreg[7];
        shreg = {shreg[6:0], 1'b0};
        scl_q = 1'b1;
      end
    end else if (off == OFF_ACK_LO) begin
      scl_q = 1'b0;
    end else if (off == OFF_RELEASE) begin
      sda_q = 1'b1;
    end else begin
      scl_q = 1'b1;
    end
  endfunction

  function automatic void read_byte_phase(logic [STEP_W-1:0] off);
    if (off == 0) begin
      sda_q = 1'b1;
      scl_q = 1'b0;
      shreg = '0;
    end else if (off <= OFF_ACK_LO) begin
      scl_q = off[0];
    end else if (off == OFF_RELEASE) begin
      sda_q = 1'b1;
    end else begin
      scl_q = 1'b1;
    end
  endfunction

  function automatic void enter_step(logic [STEP_W-1:0] s);
    if (s == STEP_START || s == STEP_RESTART) begin
      sda_q = 1'b1;
      scl_q = 1'b1;
    end else if (s == STEP_START_LO || s == STEP_RESTART_LO) begin
      sda_q = 1'b0;
    end else if (s >= STEP_WR_DEV && s < STEP_WR_REG) begin
      write_byte_phase(s - STEP_WR_DEV, dev_addr);
    end else if (s >= STEP_WR_REG && s < STEP_RESTART) begin
      write_byte_phase(s - STEP_WR_REG, latched_reg);
    end else if (s >= STEP_WR_RD && s < STEP_RD_DATA) begin
      write_byte_phase(s - STEP_WR_RD, dev_addr | READ_BIT);
    end else if (s >= STEP_RD_DATA && s < STEP_STOP_LO) begin
      read_byte_phase(s - STEP_RD_DATA);
    end else if (s == STEP_STOP_LO) begin
      sda_q = 1'b0;
      scl_q = 1'b1;
    end else if (s == STEP_LAST) begin
      sda_q = 1'b1;
    end
  endfunction

  function automatic out_t predict_tick(in_t w);
    out_t              r;
    logic [32:0]       lim;
    logic [STEP_W-1:0] off;
    if (step == STEP_IDLE && w.start_read) begin
      latched_reg = w.reg_addr;
      step        = STEP_START;
      hold_count  = '0;
      enter_step(STEP_START);
    end
    r.scl_level = scl_q;
    r.sda_drive = sda_q;
    r.busy_res  = 1'b0;
    r.done_res  = 1'b0;
    if (step != STEP_IDLE) begin
      r.busy_res = 1'b1;
      lim = 33'(hold_ticks);
      if (lim > CNT_MAX) lim = CNT_MAX;
      if (lim == 0) lim = 33'd1;
      hold_count = hold_count + 1'b1;
      if (33'(hold_count) >= lim) begin
        hold_count = '0;
        off = step - STEP_RD_DATA;
        // read bits are taken at the end of each clock-high phase
        if (step > STEP_RD_DATA && step < STEP_RD_DATA + OFF_ACK_LO && off[0])
          shreg = {shreg[6:0], w.sda_in};
        if (step >= STEP_LAST) begin
          last_byte  = shreg;
          step       = STEP_IDLE;
          scl_q      = 1'b1;
          sda_q      = 1'b1;
          r.done_res = 1'b1;
        end else begin
          step = step + 1'b1;
          enter_step(step);
        end
      end
    end
    r.read_data = last_byte;
    return r;
  endfunction

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  initial reset_model();

  always @(posedge clk) begin
    out_t e;
    if (rst) begin
      reset_model();
      expected_bus_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bus_words.size() == 0) begin
          $error("output word with no expectation");
          mismatches++;
        end else begin
          e = expected_bus_words.pop_front();
          check_field("scl_level", 8'(e.scl_level), 8'(out_data.scl_level));
          check_field("sda_drive", 8'(e.sda_drive), 8'(out_data.sda_drive));
          check_field("busy_res", 8'(e.busy_res), 8'(out_data.busy_res));
          check_field("done_res", 8'(e.done_res), 8'(out_data.done_res));
          check_field("read_data", e.read_data, out_data.read_data);
        end
      end
      if (in_valid && in_ready) expected_bus_words.push_back(predict_tick(in_data));
      if (cfg_write) begin
        if (cfg_index == CFG_DEV_ADDR) dev_addr = cfg_data[7:0];
        else hold_ticks = cfg_data[PHASE_TICKS_W-1:0];
      end
    end
    pending <= expected_bus_words.size();
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// Top of the I2C register read master bench: clock, reset, tick stimulus,
// config phases and verdict. Depends on i2crr_pkg, the core and i2crr_bus_checker.
module tb_top;
  import i2crr_pkg::*;

  localparam int LIMIT = 1000000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_t                   in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  out_t                  out_data;
  logic                  cfg_write = 1'b0;
  logic                  cfg_index = CFG_DEV_ADDR;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    errors;
  int                    pending;
  int                    cycles = 0;
  logic                  quiet = 1'b0;
  int                    quiet_left = 0;
  int                    stall_left = 0;

  always #5 clk = ~clk;

  i2c_register_read_master_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  i2crr_bus_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  function automatic int pick_delay();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_t mk_word(logic start, logic [7:0] addr, logic sda);
    in_t w;
    w.start_read = start;
    w.reg_addr   = addr;
    w.sda_in     = sda;
    return w;
  endfunction

  function automatic in_t random_tick();
    int   r;
    logic [7:0] addr;
    r = $urandom_range(0, 9);
    if (r == 0) addr = 8'h00;
    else if (r == 1) addr = 8'hFF;
    else addr = 8'($urandom_range(0, 255));
    return mk_word($urandom_range(0, 99) < 30, addr, 1'($urandom_range(0, 1)));
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // alternate between calm stretches and stretches with gaps
  always @(posedge clk) begin
    if (quiet_left == 0) begin
      quiet      <= ($urandom_range(0, 3) == 0);
      quiet_left <= $urandom_range(40, 200);
    end else begin
      quiet_left <= quiet_left - 1;
    end
  end

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 99) < 25) stall_left <= pick_delay();
    end
  end

  task automatic send_word(in_t w);
    int gap;
    gap = pick_delay();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_config(logic [7:0] dev, logic [15:0] ticks);
    cfg_write <= 1'b1;
    cfg_index <= CFG_DEV_ADDR;
    cfg_data  <= CFG_DATA_W'(dev);
    @(posedge clk);
    cfg_index <= CFG_PHASE_TICKS;
    cfg_data  <= ticks;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic run_phase(logic [7:0] dev, logic [15:0] ticks, int n);
    wait_drained();
    write_config(dev, ticks);
    repeat (n) begin
      send_word(random_tick());
      if ($urandom_range(0, 199) == 0) wait_drained();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults after reset; start, then starts while busy are ignored
    send_word(mk_word(1'b0, 8'h00, 1'b0));
    send_word(mk_word(1'b0, 8'hFF, 1'b1));
    send_word(mk_word(1'b1, 8'hFF, 1'b1));
    send_word(mk_word(1'b1, 8'h00, 1'b0));
    send_word(mk_word(1'b1, 8'h5A, 1'b1));
    for (int i = 0; i < 8; i++) send_word(mk_word(1'b0, 8'hA5, 1'(i)));

    // config writes land mid-sequence on purpose
    run_phase(8'h00, 16'd1, 200);
    run_phase(8'hFE, 16'd0, 200);
    run_phase(8'($urandom_range(0, 254)), 16'($urandom_range(1, 4)), 200);
    run_phase(8'hD0, 16'd3, 200);
    run_phase(8'($urandom_range(0, 254)), 16'hFFFF, 30);
    run_phase(8'($urandom_range(0, 254)), 16'd1, 200);
    run_phase(8'($urandom_range(0, 254)), 16'd2, 200);
    run_phase(8'($urandom_range(0, 254)), 16'd1, 360);

    wait_drained();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> i2c_register_read_master_core.f
rtl/i2crr_pkg.sv
rtl/i2crr_phase.sv
rtl/i2c_register_read_master_core.sv
test/i2crr_bus_checker.sv
test/tb_top.sv
